@@ hdl/murmur2_bucket_hash_assert.svh @@
// Assertion macros for the bucket hash block.
// Used by the top level; no other dependencies.
`ifndef MURMUR2_BUCKET_HASH_ASSERT_SVH
`define MURMUR2_BUCKET_HASH_ASSERT_SVH
`ifndef SYNTHESIS
`define MBH_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mbh: invariant violated");
`define MBH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbh: implication violated");
`else
`define MBH_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define MBH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mbh_pkg.sv @@
// Shared types and constants of the bucket hash block.
// No dependencies.
package mbh_pkg;

    localparam int KEY_W      = 32;
    localparam int NB_W       = 3;
    localparam int KLEN_W     = 16;
    localparam int HASH_W     = 32;
    localparam int BKT_W      = 16;
    localparam int TS_W       = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = $clog2(HASH_W);

    localparam int MAX_TABLE_SIZE = 65536;

    localparam logic [HASH_W-1:0] MIX_MULT = 32'h5bd1e995;
    localparam int MIX_SHIFT   = 24;
    localparam int FIN_SHIFT_A = 13;
    localparam int FIN_SHIFT_B = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;
    localparam logic [TS_W-1:0]      TS_RESET       = 17'd1024;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_TAIL = 2'd1,
        K_FULL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [KEY_W-1:0]  key_word;
        logic [NB_W-1:0]   valid_bytes;
        logic              last_word;
        logic [KLEN_W-1:0] key_length;
    } t_in;

    typedef struct packed {
        logic [HASH_W-1:0] raw_hash;
        logic [BKT_W-1:0]  bucket_index;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]  word;
        t_kind             kind;
        logic              last;
        logic              first;
        logic [HASH_W-1:0] init;
    } t_qent;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic in_div;
        logic idle;
    } t_back_stat;

endpackage

@@ hdl/mbh_front.sv @@
// Front end: accepts key words, masks tail bytes, tags key starts.
// Depends on mbh_pkg.
module mbh_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  mbh_pkg::t_in              i_in,
    input  logic [mbh_pkg::HASH_W-1:0] i_hash_seed,
    input  mbh_pkg::t_q_stat          i_qstat,
    output logic                      o_push,
    output mbh_pkg::t_qent            o_ent
);

    logic r_in_key;

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    always_comb begin
        o_ent.word  = i_in.key_word;
        o_ent.kind  = mbh_pkg::K_FULL;
        o_ent.last  = i_in.last_word;
        o_ent.first = !r_in_key;
        o_ent.init  = i_hash_seed ^ {{(mbh_pkg::HASH_W-mbh_pkg::KLEN_W){1'b0}},
                                     i_in.key_length};
        case (i_in.valid_bytes) inside
            3'd0: begin
                o_ent.kind = mbh_pkg::K_NONE;
            end
            [3'd1:3'd3]: begin
                o_ent.kind = mbh_pkg::K_TAIL;
                case (i_in.valid_bytes)
                    3'd1:    o_ent.word = i_in.key_word & 32'h0000_00ff;
                    3'd2:    o_ent.word = i_in.key_word & 32'h0000_ffff;
                    default: o_ent.word = i_in.key_word & 32'h00ff_ffff;
                endcase
            end
            default: begin
                o_ent.kind = mbh_pkg::K_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_key <= 1'b0;
        end else if (o_push) begin
            r_in_key <= !i_in.last_word;
        end
    end

endmodule

@@ hdl/mbh_queue.sv @@
// Two-entry queue between the front end and the hash engine.
// Depends on mbh_pkg.
module mbh_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbh_pkg::t_qent    i_ent,
    input  logic              i_pop,
    output mbh_pkg::t_qent    o_ent,
    output mbh_pkg::t_q_stat  o_stat
);

    mbh_pkg::t_qent                 r_mem [mbh_pkg::QDEPTH];
    logic [mbh_pkg::QPTR_W-1:0]     r_wptr;
    logic [mbh_pkg::QPTR_W-1:0]     r_rptr;
    logic [mbh_pkg::QCNT_W-1:0]     r_count;

    assign o_ent        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == mbh_pkg::QCNT_W'(mbh_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/mbh_mod.sv @@
// Bit-serial remainder unit: 32-bit hash modulo a 17-bit table size.
// Depends on mbh_pkg.
module mbh_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mbh_pkg::HASH_W-1:0] i_dividend,
    input  logic [mbh_pkg::TS_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [mbh_pkg::BKT_W-1:0]  o_rem
);

    logic [mbh_pkg::HASH_W-1:0] r_dvd;
    logic [mbh_pkg::TS_W-1:0]   r_div;
    logic [mbh_pkg::TS_W-1:0]   r_rem;
    logic [mbh_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [mbh_pkg::TS_W:0]     w_trial;
    logic [mbh_pkg::TS_W:0]     w_diff;
    logic [mbh_pkg::TS_W-1:0]   n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[mbh_pkg::HASH_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = (w_trial >= {1'b0, r_div}) ? w_diff[mbh_pkg::TS_W-1:0]
                                             : w_trial[mbh_pkg::TS_W-1:0];
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[mbh_pkg::BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= mbh_pkg::CNT_W'(mbh_pkg::HASH_W - 1);
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

endmodule

@@ hdl/mbh_back.sv @@
// Hash engine: mixing, tail and finalization on one shared multiplier,
// then bucket reduction and the output register. Depends on mbh_pkg, mbh_mod.
module mbh_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mbh_pkg::t_q_stat           i_qstat,
    input  mbh_pkg::t_qent             i_ent,
    output logic                       o_pop,
    input  logic [mbh_pkg::TS_W-1:0]   i_size,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mbh_pkg::t_out              o_out,
    output mbh_pkg::t_back_stat        o_stat
);

    typedef enum logic [7:0] {
        S_LOAD   = 8'b0000_0001,
        S_MIXK   = 8'b0000_0010,
        S_MIXH   = 8'b0000_0100,
        S_MIXEND = 8'b0000_1000,
        S_TAIL   = 8'b0001_0000,
        S_FINMUL = 8'b0010_0000,
        S_FINEND = 8'b0100_0000,
        S_DIV    = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [mbh_pkg::HASH_W-1:0]  r_h, n_h;
    logic [mbh_pkg::HASH_W-1:0]  r_k, n_k;
    logic [mbh_pkg::HASH_W-1:0]  r_raw, n_raw;
    logic                        r_last, n_last;
    logic [mbh_pkg::HASH_W-1:0]  r_prod;
    logic                        r_out_valid;
    mbh_pkg::t_out               r_out;

    logic [mbh_pkg::HASH_W-1:0]  w_h0;
    logic [mbh_pkg::HASH_W-1:0]  w_op;
    logic [mbh_pkg::HASH_W-1:0]  w_fin;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [mbh_pkg::BKT_W-1:0]   w_rem;
    logic                        w_out_free;
    logic                        w_load;

    assign w_h0       = i_ent.first ? i_ent.init : r_h;
    assign w_fin      = r_prod ^ (r_prod >> mbh_pkg::FIN_SHIFT_B);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_LOAD) && !i_qstat.empty;
    assign w_div_start = (r_state == S_FINEND);
    assign w_load     = (r_state == S_DIV) && w_div_done && w_out_free;

    always_comb begin
        case (r_state)
            S_LOAD:  w_op = (i_ent.kind == mbh_pkg::K_FULL) ? i_ent.word
                                                             : (w_h0 ^ i_ent.word);
            S_MIXK:  w_op = r_prod ^ (r_prod >> mbh_pkg::MIX_SHIFT);
            S_MIXH:  w_op = r_h;
            default: w_op = r_h ^ (r_h >> mbh_pkg::FIN_SHIFT_A);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_k     = r_k;
        n_raw   = r_raw;
        n_last  = r_last;
        case (r_state)
            S_LOAD: begin
                if (!i_qstat.empty) begin
                    n_h    = w_h0;
                    n_last = i_ent.last;
                    case (i_ent.kind)
                        mbh_pkg::K_FULL: n_state = S_MIXK;
                        mbh_pkg::K_TAIL: n_state = S_TAIL;
                        default:         n_state = i_ent.last ? S_FINMUL : S_LOAD;
                    endcase
                end
            end
            S_MIXK: begin
                n_state = S_MIXH;
            end
            S_MIXH: begin
                n_k     = r_prod;
                n_state = S_MIXEND;
            end
            S_MIXEND: begin
                n_h     = r_prod ^ r_k;
                n_state = r_last ? S_FINMUL : S_LOAD;
            end
            S_TAIL: begin
                n_h     = r_prod;
                n_state = r_last ? S_FINMUL : S_LOAD;
            end
            S_FINMUL: begin
                n_state = S_FINEND;
            end
            S_FINEND: begin
                n_raw   = w_fin;
                n_h     = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_load) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_op * mbh_pkg::MIX_MULT;
        r_h    <= n_h;
        r_k    <= n_k;
        r_raw  <= n_raw;
        r_last <= n_last;
        if (w_load) begin
            r_out.raw_hash     <= r_raw;
            r_out.bucket_index <= w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    mbh_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_fin),
        .i_divisor  (i_size),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out         = r_out;
    assign o_stat.in_div = (r_state == S_DIV);
    assign o_stat.idle   = (r_state == S_LOAD);

endmodule

@@ hdl/murmur2_bucket_hash.sv @@
// MurmurHash2 (32-bit) over little-endian key words, reduced to a bucket
// index modulo the table size. A two-entry request queue separates the front
// end from the hash engine, and the result sits in an output register. The
// engine uses one 32x32 multiplier for all mixing: a full word passes S_MIXK,
// S_MIXH and S_MIXEND, a tail word S_TAIL. The last word of a key adds
// finalization, then the bit-serial remainder unit and result load.
// Depends on mbh_pkg, mbh_front, mbh_queue, mbh_back and the assertion header.
`include "murmur2_bucket_hash_assert.svh"

module murmur2_bucket_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mbh_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mbh_pkg::t_out                   o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [mbh_pkg::HASH_W-1:0] r_hash_seed;
    logic [mbh_pkg::TS_W-1:0]   r_table_size;
    logic [mbh_pkg::TS_W-1:0]   w_size;

    logic                       w_push;
    logic                       w_pop;
    mbh_pkg::t_qent             w_ent_in;
    mbh_pkg::t_qent             w_ent_out;
    mbh_pkg::t_q_stat           w_qstat;
    mbh_pkg::t_back_stat        w_bstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed  <= '0;
            r_table_size <= mbh_pkg::TS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbh_pkg::CFG_HASH_SEED:  r_hash_seed  <= i_cfg_data;
                mbh_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data[mbh_pkg::TS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            w_size = mbh_pkg::TS_W'(1);
        end else if (r_table_size > mbh_pkg::TS_W'(mbh_pkg::MAX_TABLE_SIZE)) begin
            w_size = mbh_pkg::TS_W'(mbh_pkg::MAX_TABLE_SIZE);
        end else begin
            w_size = r_table_size;
        end
    end

    mbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_hash_seed (r_hash_seed),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_ent       (w_ent_in)
    );

    mbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_ent_in),
        .i_pop   (w_pop),
        .o_ent   (w_ent_out),
        .o_stat  (w_qstat)
    );

    mbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_ent       (w_ent_out),
        .o_pop       (w_pop),
        .i_size      (w_size),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_stat      (w_bstat)
    );

    `MBH_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, w_qstat.count <= mbh_pkg::QCNT_W'(mbh_pkg::QDEPTH))
    `MBH_ASSERT_IMPLY(a_result_from_div, i_clk, i_rst_n, $rose(o_out_valid), $past(w_bstat.in_div))
    `MBH_ASSERT_IMPLY(a_div_no_pop, i_clk, i_rst_n, w_bstat.in_div, !w_pop && !w_bstat.idle)

endmodule

@@ tb/murmur2_bucket_hash_tb.sv @@
// Self-checking testbench for murmur2_bucket_hash: feeds keys word by word under
// random idling and stalls, predicts each raw hash and bucket index, checks in order.
// Depends on mbh_pkg and the murmur2_bucket_hash RTL.
module murmur2_bucket_hash_tb;
    import mbh_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int ITEMS         = 1650;
    localparam int NUM_PHASES    = 10;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int WORD_BYTES    = 4;

    class bucket_scoreboard;
        logic [HASH_W-1:0] seed;
        logic [TS_W-1:0]   tsize;
        logic [HASH_W-1:0] run_hash;
        bit                in_key;
        t_out              expected_q[$];
        int                errors;

        function new();
            seed     = '0;
            tsize    = TS_RESET;
            run_hash = '0;
            in_key   = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_HASH_SEED) begin
                seed = data;
            end else begin
                tsize = data[TS_W-1:0];
            end
        endfunction

        function void note_request(t_in req);
            logic [HASH_W-1:0] h;
            logic [HASH_W-1:0] k;
            logic [HASH_W-1:0] mask;
            logic [HASH_W-1:0] size;
            int                nb;
            t_out              res;
            if (!in_key) begin
                run_hash = seed ^ HASH_W'(req.key_length);
                in_key   = 1'b1;
            end
            h  = run_hash;
            nb = (req.valid_bytes > WORD_BYTES) ? WORD_BYTES : int'(req.valid_bytes);
            if (nb == WORD_BYTES) begin
                k = req.key_word * MIX_MULT;
                k ^= k >> MIX_SHIFT;
                k = k * MIX_MULT;
                h = h * MIX_MULT;
                h ^= k;
            end else if (nb != 0) begin
                mask = {HASH_W{1'b1}} >> (8 * (WORD_BYTES - nb));
                h ^= req.key_word & mask;
                h = h * MIX_MULT;
            end
            run_hash = h;
            if (req.last_word) begin
                size = HASH_W'(tsize);
                if (size == 0) size = 1;
                if (size > MAX_TABLE_SIZE) size = MAX_TABLE_SIZE;
                h ^= h >> FIN_SHIFT_A;
                h = h * MIX_MULT;
                h ^= h >> FIN_SHIFT_B;
                res.raw_hash     = h;
                res.bucket_index = BKT_W'(h % size);
                expected_q.push_back(res);
                run_hash = '0;
                in_key   = 1'b0;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, raw_hash %h bucket_index %h",
                         $time, got.raw_hash, got.bucket_index);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.raw_hash !== want.raw_hash) begin
                $display("%0t: raw_hash mismatch, expected %h, actual %h",
                         $time, want.raw_hash, got.raw_hash);
                errors++;
            end
            if (got.bucket_index !== want.bucket_index) begin
                $display("%0t: bucket_index mismatch, expected %h, actual %h",
                         $time, want.bucket_index, got.bucket_index);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bucket_scoreboard sb = new();
    bit               in_gap_on;
    bit               out_stall_on;
    bit               hold_req;
    int               items_sent;

    murmur2_bucket_hash u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [KEY_W-1:0] word, int vb, bit last, logic [KLEN_W-1:0] klen);
        t_in req;
        int  gap;
        req.key_word    = word;
        req.valid_bytes = NB_W'(vb);
        req.last_word   = last;
        req.key_length  = klen;
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
        items_sent++;
        gap = (in_gap_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // well-formed key: full words, then a tail or full last word; empty key is one 0-byte word
    task automatic send_random_key();
        int              len;
        int              words;
        int              tail;
        int              r;
        logic [KLEN_W-1:0] klen;
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 24);
        else if (r < 95) len = $urandom_range(25, 64);
        else             len = 0;
        klen  = ($urandom_range(0, 99) < 80) ? KLEN_W'(len) : KLEN_W'($urandom);
        words = (len == 0) ? 1 : (len + 3) / 4;
        tail  = len % WORD_BYTES;
        for (int i = 0; i < words; i++) begin
            send_word($urandom,
                      (i < words - 1) ? WORD_BYTES :
                      ((len == 0) ? 0 : ((tail == 0) ? WORD_BYTES : tail)),
                      i == words - 1,
                      (i == 0) ? klen : KLEN_W'($urandom));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (out_stall_on && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] seed_val;
        logic [CFG_DATA_W-1:0] size_val;
        int                    target;
        in_gap_on    = 1'b1;
        out_stall_on = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests under reset configuration
        send_word('0, 0, 1'b1, '0);                    // empty key
        send_word('1, 4, 1'b1, 16'd4);
        send_word('0, 4, 1'b1, 16'd4);
        send_word('1, 1, 1'b1, 16'd1);
        send_word('1, 2, 1'b1, 16'd2);
        send_word('1, 3, 1'b1, 16'd3);
        send_word(32'h12345678, 4, 1'b0, 16'd7);
        send_word(32'hffabcdef, 3, 1'b1, '1);          // later key_length ignored
        send_word($urandom, 7, 1'b1, '1);              // oversized byte count
        send_word($urandom, 5, 1'b1, 16'd9);
        send_word($urandom, 6, 1'b0, 16'd12);
        send_word($urandom, 0, 1'b0, '0);              // empty word inside a key
        send_word($urandom, 2, 1'b1, '0);
        send_word($urandom, 2, 1'b0, 16'd10);          // short word not last
        send_word($urandom, 4, 1'b0, '0);
        send_word($urandom, 4, 1'b1, '0);
        send_word($urandom, 1, 1'b1, 16'd100);         // length mismatch
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            seed_val = $urandom;
            case (ph)
                0: begin
                    seed_val = '0;
                    size_val = 1;
                end
                1: begin
                    seed_val = '1;
                    size_val = MAX_TABLE_SIZE;
                end
                2: size_val = 0;
                3: size_val = CFG_DATA_W'(TS_RESET);
                4: size_val = 32'h0001_ffff;
                5: size_val = '1;
                6: size_val = 65535;
                7: size_val = 3;
                8: size_val = 32'h0002_0400;
                default: size_val = $urandom_range(1, MAX_TABLE_SIZE);
            endcase
            write_reg(CFG_HASH_SEED, seed_val);
            write_reg(CFG_TABLE_SIZE, size_val);
            in_gap_on    = (ph % 3 != 1);
            out_stall_on = (ph % 4 != 2);
            if (ph == 3) begin
                // back-pressure: sink holds off while requests keep coming
                in_gap_on = 1'b0;
                hold_req  = 1'b1;
            end
            target = items_sent + ITEMS / NUM_PHASES;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_random_key();
                end else begin
                    send_word($urandom, $urandom_range(0, 7), $urandom_range(0, 3) == 0,
                              KLEN_W'($urandom));
                end
            end
            send_random_key();
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule
